// ----- rtl/psrl_pkg.sv -----
package psrl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TTL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT = 8'd1;

  localparam logic [31:0] TTL_RESET = 32'd60;
  localparam logic [31:0] LIMIT_RESET = 32'd60;

  typedef struct packed {
    logic        addr_family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rate_per_minute;
    logic        blocked;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [31:0]            wdata;
  } cfg_item_t;

  typedef struct packed {
    logic        family;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [31:0] count;
  } entry_t;

endpackage

// ----- rtl/psrl_if.sv -----
interface psrl_in_if;
  import psrl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psrl_out_if;
  import psrl_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psrl_cfg_if;
  import psrl_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/psrl_ram.sv -----
module psrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/per_source_rate_limiter.sv -----
// Per-address fixed-window rate limiter. Each request transaction is looked up in a table
// of TABLE_ENTRIES counters held in one RAM, searched linearly with a read and a compare
// state per occupied entry; the count is then updated, the window age checked against
// window_ttl_seconds, the whole minutes of the window formed by a reciprocal
// multiplication, and the hits per minute worked out as count / minutes by a bit-serial
// divider. The rate is zero, with no division, if the table is full, the window restarts
// or the time is not past the window start. After a request is accepted, in_ch.ready
// stays low until its result transaction has been taken. Entries are filled from index
// zero and only ever cleared all together, so a fill count stands in for per-entry valid
// bits and no clearing pass is needed after reset or a window restart. Configuration
// writes are always accepted and should be made only while the block is idle.
module per_source_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
  input logic clk,
  input logic rst_n,
  psrl_in_if.sink    in_ch,
  psrl_out_if.source out_ch,
  psrl_cfg_if.sink   cfg_ch
);
  import psrl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_WIN  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_MIN  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  in_item_t      item_r, item_nxt;
  logic [31:0]   ttl_r, limit_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [31:0]   wstart_r, wstart_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  logic          full_r, full_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [31:0]   dvs_r, dvs_nxt;
  logic [4:0]    step_r, step_nxt;
  out_item_t     out_r, out_nxt;

  entry_t        rd_entry, wr_entry;
  logic [160:0]  rd_raw;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  logic [32:0]   rem_sh, rem_sub;
  logic          ge;
  logic [31:0]   quo_step;
  logic [31:0]   age;
  logic          match, last_entry;
  logic [61:0]   min_prod;
  logic [31:0]   minutes;

  psrl_ram #(.WIDTH(161), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (idx_r),
    .rdata (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign wr_entry = '{family: item_r.addr_family, key_high: item_r.addr_high,
                      key_low: item_r.addr_low, count: cnt_r};
  assign ram_we = (state_r == S_WR);
  assign ram_waddr = idx_r;

  assign match = (rd_entry.family == item_r.addr_family) &&
                 (rd_entry.key_high == item_r.addr_high) &&
                 (rd_entry.key_low == item_r.addr_low);
  assign last_entry = (FW'(idx_r) + FW'(1)) == fill_r;

  assign rem_sh = {rem_r[31:0], quo_r[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge = !rem_sub[32];
  assign quo_step = {quo_r[30:0], ge};
  assign age = item_r.now_seconds - wstart_r;

  // Whole minutes are (span / 4) / 15, the latter by the rounded-up reciprocal of 15.
  assign min_prod = 62'(quo_r[31:2]) * 62'(32'h8888_8889);
  assign minutes = {5'd0, min_prod[61:35]};

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = out_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    fill_nxt = fill_r;
    wstart_nxt = wstart_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    found_nxt = found_r;
    full_nxt = full_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    step_nxt = step_r;
    out_nxt = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          idx_nxt = '0;
          found_nxt = 1'b0;
          full_nxt = 1'b0;
          if (fill_r == '0) begin
            cnt_nxt = 32'd1;
            found_nxt = 1'b1;
            state_nxt = S_WR;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          found_nxt = 1'b1;
          cnt_nxt = (rd_entry.count == 32'hFFFF_FFFF) ? rd_entry.count
                                                        : rd_entry.count + 32'd1;
          state_nxt = S_WR;
        end else if (last_entry) begin
          if (fill_r == FW'(TABLE_ENTRIES)) begin
            full_nxt = 1'b1;
            state_nxt = S_WIN;
          end else begin
            found_nxt = 1'b1;
            idx_nxt = fill_r[AW-1:0];
            cnt_nxt = 32'd1;
            fill_nxt = fill_r + FW'(1);
            state_nxt = S_WR;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        if (fill_r == '0) begin
          fill_nxt = FW'(1);
        end
        state_nxt = S_WIN;
      end
      S_WIN: begin
        out_nxt = '{rate_per_minute: 32'd0, blocked: 1'b0, table_full: full_r};
        if (item_r.now_seconds >= wstart_r && age > ttl_r) begin
          fill_nxt = '0;
          wstart_nxt = item_r.now_seconds;
          state_nxt = S_OUT;
        end else if (item_r.now_seconds <= wstart_r || !found_r) begin
          state_nxt = S_OUT;
        end else begin
          quo_nxt = age;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        rem_nxt = '0;
        quo_nxt = cnt_r;
        dvs_nxt = (minutes == 32'd0) ? 32'd1 : minutes;
        step_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? rem_sub : rem_sh;
        quo_nxt = quo_step;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          out_nxt.rate_per_minute = quo_step;
          out_nxt.blocked = quo_step > limit_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      wstart_r <= '0;
      ttl_r <= TTL_RESET;
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      wstart_r <= wstart_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.data.reg_index)
          REG_WINDOW_TTL: ttl_r <= cfg_ch.data.wdata;
          REG_LIMIT: limit_r <= cfg_ch.data.wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    found_r <= found_nxt;
    full_r <= full_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    step_r <= step_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(TABLE_ENTRIES)) else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != $past(fill_r) |-> fill_r == '0 || fill_r == $past(fill_r) + FW'(1))
    else $error("fill count moved by more than one entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready && !out_ch.valid)
    else $error("block not busy after taking a request");

  a_full_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_r.table_full |-> out_r.rate_per_minute == 32'd0)
    else $error("uncounted request reported a rate");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import psrl_pkg::*;

  localparam int unsigned NUM_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned POOL_SIZE = 12;
  localparam int unsigned STALL_LIMIT = 20000;

  class rate_scoreboard;
    bit          used[NUM_ENTRIES];
    bit          fam[NUM_ENTRIES];
    bit [63:0]   key_hi[NUM_ENTRIES];
    bit [63:0]   key_lo[NUM_ENTRIES];
    bit [31:0]   hits[NUM_ENTRIES];
    bit [31:0]   win_start;
    bit [31:0]   ttl;
    bit [31:0]   limit;
    out_item_t   expected_q[$];
    int          errors;
    int          checked;
    int          blocked_seen;
    int          full_seen;
    int          restarts;

    function new();
      ttl = TTL_RESET;
      limit = LIMIT_RESET;
    endfunction

    function void set_reg(cfg_item_t c);
      if (c.reg_index == REG_WINDOW_TTL) begin
        ttl = c.wdata;
      end else if (c.reg_index == REG_LIMIT) begin
        limit = c.wdata;
      end
    endfunction

    function int find_key(bit f, bit [63:0] hi, bit [63:0] lo);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (used[i] && fam[i] == f && key_hi[i] == hi && key_lo[i] == lo) return i;
      end
      return -1;
    endfunction

    function void note_request(in_item_t it);
      int        idx;
      bit [31:0] span;
      bit [31:0] mins;
      out_item_t res;
      res = '0;
      idx = find_key(it.addr_family, it.addr_high, it.addr_low);
      if (idx >= 0) begin
        if (hits[idx] != 32'hFFFF_FFFF) hits[idx]++;
      end else begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!used[i]) begin
            idx = i;
            break;
          end
        end
        if (idx >= 0) begin
          used[idx] = 1'b1;
          fam[idx] = it.addr_family;
          key_hi[idx] = it.addr_high;
          key_lo[idx] = it.addr_low;
          hits[idx] = 32'd1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      if (it.now_seconds >= win_start && it.now_seconds - win_start > ttl) begin
        for (int i = 0; i < NUM_ENTRIES; i++) used[i] = 1'b0;
        win_start = it.now_seconds;
        restarts++;
      end
      if (it.now_seconds >= win_start) begin
        span = it.now_seconds - win_start;
        idx = find_key(it.addr_family, it.addr_high, it.addr_low);
        if (idx >= 0 && span != 0) begin
          mins = span / SECONDS_PER_MINUTE;
          if (mins == 0) mins = 1;
          res.rate_per_minute = hits[idx] / mins;
        end
      end
      res.blocked = res.rate_per_minute > limit;
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: result transaction with none expected: rate %0d blocked %0d full %0d",
                 $time, got.rate_per_minute, got.blocked, got.table_full);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.blocked) blocked_seen++;
      if (exp.table_full) full_seen++;
      if (got.rate_per_minute !== exp.rate_per_minute) begin
        $display("%0t: rate_per_minute expected %0d actual %0d", $time,
                 exp.rate_per_minute, got.rate_per_minute);
        errors++;
      end
      if (got.blocked !== exp.blocked) begin
        $display("%0t: blocked expected %0d actual %0d", $time, exp.blocked, got.blocked);
        errors++;
      end
      if (got.table_full !== exp.table_full) begin
        $display("%0t: table_full expected %0d actual %0d", $time,
                 exp.table_full, got.table_full);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  psrl_in_if  in_ch();
  psrl_out_if out_ch();
  psrl_cfg_if cfg_ch();

  per_source_rate_limiter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rate_scoreboard sb = new();

  bit        quiet;
  bit [31:0] now_t;
  in_item_t  pool[POOL_SIZE];
  int        idle_cycles;
  int        sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int k;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      k = quiet ? 0 : $urandom_range(0, 18);
      if (k > 0) begin
        out_ch.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_item_t c;
    c.reg_index = idx;
    c.wdata = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(c);
  endtask

  task automatic send_request(bit f, logic [63:0] hi, logic [63:0] lo, logic [31:0] t);
    in_item_t it;
    int       gap;
    it.addr_family = f;
    it.addr_high = hi;
    it.addr_low = lo;
    it.now_seconds = t;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(it);
    sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic fill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i].addr_family = 1'($urandom_range(0, 1));
      pool[i].addr_high = pool[i].addr_family ? {$urandom, $urandom} : 64'd0;
      pool[i].addr_low = pool[i].addr_family ? {$urandom, $urandom} : {32'd0, $urandom};
    end
    pool[1] = pool[0];
    pool[1].addr_family = ~pool[0].addr_family;
  endtask

  task automatic random_phase(int n, logic [31:0] ttl, logic [31:0] lim);
    int r;
    int p;
    write_reg(REG_WINDOW_TTL, ttl);
    write_reg(REG_LIMIT, lim);
    fill_pool();
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) now_t = now_t - $urandom_range(1, 100);
      else if (r < 10) now_t = now_t + $urandom_range(0, 2000);
      else now_t = now_t + $urandom_range(0, 30);
      p = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < 15) begin
        send_request(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                     now_t);
      end else begin
        send_request(pool[p].addr_family, pool[p].addr_high, pool[p].addr_low, now_t);
      end
    end
    quiet = 1'b0;
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    quiet = 1'b0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset configuration.
    send_request(1'b0, 64'd0, 64'd0, 32'd0);
    send_request(1'b0, 64'd0, 64'd0, 32'd0);
    send_request(1'b1, 64'd0, 64'd0, 32'd0);
    send_request(1'b1, '1, '1, 32'd30);
    send_request(1'b1, '1, '1, 32'd59);
    send_request(1'b0, 64'd0, 64'd0, 32'd60);
    send_request(1'b0, 64'd0, 64'hFFFF_FFFF, 32'd60);
    send_request(1'b0, 64'd1, 64'hFFFF_FFFF, 32'd60);
    send_request(1'b0, 64'd0, 64'd0, 32'd61);
    send_request(1'b0, 64'd0, 64'd0, 32'd90);
    send_request(1'b0, 64'd0, 64'd0, 32'd121);
    send_request(1'b0, 64'd0, 64'd0, 32'd122);
    send_request(1'b0, 64'd0, 64'd0, 32'd5);
    send_request(1'b1, 64'h8000_0000_0000_0000, 64'd1, 32'd150);
    send_request(1'b1, 64'h8000_0000_0000_0000, 64'd1, 32'd240);
    send_request(1'b1, 64'h8000_0000_0000_0000, 64'd1, 32'hFFFF_FFFF);
    send_request(1'b1, 64'h8000_0000_0000_0000, 64'd1, 32'hFFFF_FFFF);
    settle();

    write_reg(REG_WINDOW_TTL, 32'hFFFF_FFFF);
    write_reg(REG_LIMIT, 32'd0);
    now_t = 32'd1000;
    send_request(1'b0, 64'd0, 64'd7, now_t);
    for (int i = 0; i < NUM_ENTRIES + 4; i++) begin
      now_t = now_t + $urandom_range(0, 3);
      send_request(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                   now_t);
    end
    send_request(1'b0, 64'd0, 64'd7, now_t + 32'd600);
    settle();

    now_t = $urandom;
    random_phase(150, 32'd60, 32'd60);
    random_phase(150, 32'd300, 32'd1);
    random_phase(130, 32'd0, 32'd0);
    now_t = 32'hFFFF_F000;
    random_phase(150, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    settle();
    $display("Sent %0d requests, checked %0d results.", sent, sb.checked);
    $display("Saw %0d blocked, %0d table-full results and %0d window restarts.",
             sb.blocked_seen, sb.full_seen, sb.restarts);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
